### src/bsit_pkg.sv
// ----------------------------------------------------------------------------
// bsit_pkg
// shared constants and control types of the byte string intern table
// ----------------------------------------------------------------------------
package bsit_pkg;
  localparam int ENTRIES     = 256;
  localparam int STORE_BYTES = 4096;
  localparam int MAX_STRING  = 64;

  localparam int ID_W   = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int OFF_W  = $clog2(STORE_BYTES + 1);
  localparam int STG_AW = (MAX_STRING > 1) ? $clog2(MAX_STRING) : 1;
  localparam int LEN_W  = $clog2(MAX_STRING + 1);

  localparam logic [1:0] OP_INTERN = 2'd0;
  localparam logic [1:0] OP_CHECK  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic stage;       // write in_data_byte into staging
    logic clear;       // empty table and staging
    logic drop_stage;  // empty staging
    logic ent_start;   // begin search at entry 0
    logic ent_load;    // read end offset of current entry
    logic ent_next;    // advance to next entry
    logic cmp_start;   // reset byte compare index
    logic cmp_rd;      // issue read of one byte pair
    logic cmp_next;    // advance byte compare
    logic ins_start;   // begin copy of staging into store
    logic ins_rd;      // read one staged byte
    logic ins_wr;      // write that byte into the store
    logic ins_done;    // commit new entry
    logic res_found;   // latch found result
    logic res_added;
    logic res_full;
    logic res_none;
  } bsit_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic overflow;     // staging overflowed
    logic more_ent;     // current entry < entry_count
    logic len_match;    // current entry length equals staging length
    logic cmp_end;      // all bytes compared
    logic byte_eq;      // registered byte pair equal
    logic ins_end;      // all bytes copied
    logic no_room;      // no entry or store room
  } bsit_sts_t;
endpackage

### src/byte_string_intern_table_core.sv
// ----------------------------------------------------------------------------
// byte_string_intern_table_core
// deduplicating byte string table with fixed capacity
// ----------------------------------------------------------------------------
// Bytes are staged at one per cycle. After the last byte a decide state
// goes straight to the result on staging overflow, else the controller walks
// stored entries in id order: a load and a length check per entry, plus a
// read, a wait and a check per compared byte (one store read port,
// registered data) and a final read state when all bytes of an entry match.
// A miss state follows, an insert then copies each byte by a staging read
// and a store write, and the output state posts the result. Input is
// stalled during search and insert. Results are held in an output register.
module byte_string_intern_table_core
  import bsit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic        out_added,
  output logic        out_full_res,
  output logic [7:0]  out_entry_id,
  output logic [11:0] out_start_offset
);
  bsit_cmd_t cmd;
  bsit_sts_t sts;

  bsit_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_last,
    .out_valid, .out_ready, .sts, .cmd
  );

  bsit_datapath u_dp (
    .clk, .rst_n, .data_byte(in_data_byte), .cmd, .sts,
    .found(out_found), .added(out_added), .full_res(out_full_res),
    .entry_id(out_entry_id), .start_offset(out_start_offset)
  );
endmodule

### src/bsit_datapath.sv
// ----------------------------------------------------------------------------
// bsit_datapath
// staging buffer, byte store, end offset table and result registers
// ----------------------------------------------------------------------------
module bsit_datapath
  import bsit_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         data_byte,
  input  bsit_cmd_t          cmd,
  output bsit_sts_t          sts,
  output logic               found,
  output logic               added,
  output logic               full_res,
  output logic [7:0]         entry_id,
  output logic [11:0]        start_offset
);
  logic [7:0]       store_mem [STORE_BYTES];
  logic [7:0]       stg_mem   [MAX_STRING];
  logic [OFF_W-1:0] end_mem   [ENTRIES];  // end_mem[i] = end offset of entry i

  logic [CNT_W-1:0] count_r;
  logic [OFF_W-1:0] tail_r;               // end of last entry
  logic [LEN_W-1:0] slen_r;
  logic             ovf_r;
  logic [CNT_W-1:0] ent_r;
  logic [OFF_W-1:0] start_r;              // start of current entry
  logic [OFF_W-1:0] stop_r;
  logic [LEN_W-1:0] idx_r;
  logic [7:0]       sbyte_r, tbyte_r;
  logic             found_r, added_r, full_r;
  logic [7:0]       id_r;
  logic [11:0]      off_r;

  logic [OFF_W:0]   room;
  logic [OFF_W-1:0] stop_m_start;

  always_ff @(posedge clk) begin
    if (cmd.stage && !ovf_r && slen_r < LEN_W'(MAX_STRING))
      stg_mem[slen_r[STG_AW-1:0]] <= data_byte;
    if (cmd.ins_wr)
      store_mem[ADDR_W'(tail_r + OFF_W'(idx_r))] <= sbyte_r;
    if (cmd.ins_done)
      end_mem[count_r[ID_W-1:0]] <= tail_r + OFF_W'(slen_r);
    if (cmd.ent_load)
      stop_r <= end_mem[ent_r[ID_W-1:0]];
    if (cmd.cmp_rd || cmd.ins_rd)
      sbyte_r <= stg_mem[idx_r[STG_AW-1:0]];
    if (cmd.cmp_rd)
      tbyte_r <= store_mem[ADDR_W'(start_r + OFF_W'(idx_r))];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      tail_r  <= '0;
      slen_r  <= '0;
      ovf_r   <= 1'b0;
      found_r <= 1'b0;
      added_r <= 1'b0;
      full_r  <= 1'b0;
      id_r    <= '0;
      off_r   <= '0;
      ent_r   <= '0;
      start_r <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.clear) begin
        count_r <= '0;
        tail_r  <= '0;
      end
      if (cmd.clear || cmd.drop_stage) begin
        slen_r <= '0;
        ovf_r  <= 1'b0;
      end else if (cmd.stage) begin
        if (slen_r < LEN_W'(MAX_STRING)) slen_r <= slen_r + 1'b1;
        else                             ovf_r  <= 1'b1;
      end
      if (cmd.ent_start) begin
        ent_r   <= '0;
        start_r <= '0;
      end else if (cmd.ent_next) begin
        ent_r   <= ent_r + 1'b1;
        start_r <= stop_r;
      end
      if (cmd.cmp_start || cmd.ins_start) idx_r <= '0;
      else if (cmd.cmp_next || cmd.ins_wr) idx_r <= idx_r + 1'b1;
      if (cmd.ins_done) begin
        count_r <= count_r + 1'b1;
        tail_r  <= tail_r + OFF_W'(slen_r);
      end
      if (cmd.res_found) begin
        {found_r, added_r, full_r} <= 3'b100;
        id_r  <= 8'(ent_r);
        off_r <= 12'(start_r);
      end else if (cmd.res_added) begin
        {found_r, added_r, full_r} <= 3'b010;
        id_r  <= 8'(count_r);
        off_r <= 12'(tail_r);
      end else if (cmd.res_full) begin
        {found_r, added_r, full_r} <= 3'b001;
        id_r  <= '0;
        off_r <= '0;
      end else if (cmd.res_none) begin
        {found_r, added_r, full_r} <= 3'b000;
        id_r  <= '0;
        off_r <= '0;
      end
    end
  end

  assign stop_m_start  = stop_r - start_r;
  assign room          = (OFF_W+1)'(STORE_BYTES) - (OFF_W+1)'(tail_r);
  assign sts.overflow  = ovf_r;
  assign sts.more_ent  = ent_r < count_r;
  assign sts.len_match = (stop_r >= start_r) && (stop_m_start == OFF_W'(slen_r));
  assign sts.cmp_end   = idx_r == slen_r;
  assign sts.byte_eq   = sbyte_r == tbyte_r;
  assign sts.ins_end   = idx_r == slen_r;
  assign sts.no_room   = (count_r >= CNT_W'(ENTRIES)) || ((OFF_W+1)'(slen_r) > room);

  assign found        = found_r;
  assign added        = added_r;
  assign full_res     = full_r;
  assign entry_id     = id_r;
  assign start_offset = off_r;
endmodule

### src/bsit_ctrl.sv
// ----------------------------------------------------------------------------
// bsit_ctrl
// sequencer for staging, search, insert and result handshake
// ----------------------------------------------------------------------------
module bsit_ctrl
  import bsit_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  input  bsit_sts_t  sts,
  output bsit_cmd_t  cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_ELOAD, S_ECHK, S_CRD, S_CCHK, S_CWAIT, S_MISS, S_INS, S_IWR, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   intern_r, intern_nxt;
  logic   oval_r, oval_nxt;
  logic   acc;

  // a new request may enter in the cycle the waiting result is taken
  assign in_ready  = (state_r == S_IDLE) && !(oval_r && !out_ready);
  assign out_valid = oval_r;
  assign acc       = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    intern_nxt = intern_r;
    oval_nxt   = oval_r && !out_ready;
    cmd        = '0;
    case (state_r)
      S_IDLE: if (acc) begin
        if (in_operation == OP_CLEAR) begin
          cmd.clear    = 1'b1;
          cmd.res_none = 1'b1;
          oval_nxt     = 1'b1;
        end else begin
          cmd.stage = 1'b1;
          if (in_last) begin
            intern_nxt = in_operation == OP_INTERN;
            state_nxt  = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (sts.overflow) begin
          if (intern_r) cmd.res_full = 1'b1;
          else          cmd.res_none = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.ent_start = 1'b1;
          state_nxt     = S_ELOAD;
        end
      end
      S_ELOAD: begin
        if (sts.more_ent) begin
          cmd.ent_load = 1'b1;
          state_nxt    = S_ECHK;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_ECHK: begin
        if (sts.len_match) begin
          cmd.cmp_start = 1'b1;
          state_nxt     = S_CRD;
        end else begin
          cmd.ent_next = 1'b1;
          state_nxt    = S_ELOAD;
        end
      end
      S_CRD: begin
        if (sts.cmp_end) begin
          cmd.res_found = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          cmd.cmp_rd = 1'b1;
          state_nxt  = S_CWAIT;
        end
      end
      S_CWAIT: state_nxt = S_CCHK;
      S_CCHK: begin
        if (sts.byte_eq) begin
          cmd.cmp_next = 1'b1;
          state_nxt    = S_CRD;
        end else begin
          cmd.ent_next = 1'b1;
          state_nxt    = S_ELOAD;
        end
      end
      S_MISS: begin
        if (!intern_r) begin
          cmd.res_none = 1'b1;
          state_nxt    = S_OUT;
        end else if (sts.no_room) begin
          cmd.res_full = 1'b1;
          state_nxt    = S_OUT;
        end else begin
          cmd.ins_start = 1'b1;
          state_nxt     = S_INS;
        end
      end
      S_INS: begin
        if (sts.ins_end) begin
          cmd.res_added = 1'b1;
          cmd.ins_done  = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          cmd.ins_rd = 1'b1;
          state_nxt  = S_IWR;
        end
      end
      S_IWR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = S_INS;
      end
      S_OUT: begin
        // result registers loaded last cycle; wait for output slot
        if (!oval_r || out_ready) begin
          oval_nxt       = 1'b1;
          cmd.drop_stage = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      intern_r <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      intern_r <= intern_nxt;
      oval_r   <= oval_nxt;
    end
  end
endmodule

### src/bsit_checker.sv
// ----------------------------------------------------------------------------
// bsit_checker
// port level checks of the intern table
// ----------------------------------------------------------------------------
module bsit_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_found,
  input logic out_added,
  input logic out_full_res,
  input logic [7:0] out_entry_id
);
  a_flags_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_found, out_added, out_full_res}))
    else $error("more than one result flag");

  a_full_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_res |-> out_entry_id == 8'd0)
    else $error("full result with nonzero id");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");

  a_no_ready_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");
endmodule

bind byte_string_intern_table_core bsit_checker u_chk (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready, .out_found, .out_added,
  .out_full_res, .out_entry_id
);

### verif/tb_byte_string_intern_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_string_intern_table_core
// self-checking bench for the byte string intern table
// ----------------------------------------------------------------------------
// Byte requests are fed through a valid/ready driver. A behavioral table
// predicts found/added/full per string, and a monitor compares each result
// field by field in order. Traffic mixes repeated strings from a small pool,
// new strings, overlong strings, check-only and clear requests, and fills
// the entry limit.
module tb_byte_string_intern_table_core;
  import bsit_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       last;
  } req_t;

  typedef struct packed {
    logic        found;
    logic        added;
    logic        full;
    logic [7:0]  id;
    logic [11:0] start;
  } intern_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [7:0]  in_data_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic        out_found;
  logic        out_added;
  logic        out_full_res;
  logic [7:0]  out_entry_id;
  logic [11:0] out_start_offset;

  byte_string_intern_table_core u_dut (.*);

  // shadow table
  logic [7:0]  tbl_bytes [STORE_BYTES];
  int unsigned tbl_end [ENTRIES + 1];
  int unsigned tbl_count;
  logic [7:0]  stg_bytes [MAX_STRING];
  int unsigned stg_len;
  bit          stg_ovf;

  req_t        pending_reqs[$];
  intern_res_t expected_results[$];
  int          n_errors;
  int          n_results;
  int          n_sent;
  bit          quiet;      // no idling near the end

  // pool of strings reused to force hits
  logic [7:0] pool [16][$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void predict_table_step(req_t r);
    int unsigned i;
    int unsigned s;
    int unsigned e;
    bit          eq;
    intern_res_t res;
    res = '0;
    if (r.op == OP_CLEAR) begin
      tbl_count = 0;
      tbl_end[0] = 0;
      stg_len = 0;
      stg_ovf = 0;
      expected_results.push_back(res);
      return;
    end
    if (stg_len < MAX_STRING) begin
      stg_bytes[stg_len] = r.data;
      stg_len++;
    end else begin
      stg_ovf = 1;
    end
    if (!r.last) return;
    if (stg_ovf) begin
      res.full = (r.op == OP_INTERN);
    end else begin
      s = 0;
      for (i = 0; i < tbl_count; i++) begin
        e = tbl_end[i + 1];
        if (e - s == stg_len) begin
          eq = 1;
          for (int k = 0; k < stg_len; k++)
            if (tbl_bytes[s + k] != stg_bytes[k]) eq = 0;
          if (eq) begin
            res.found = 1;
            res.id = i[7:0];
            res.start = s[11:0];
            break;
          end
        end
        s = e;
      end
      if (!res.found && r.op == OP_INTERN) begin
        e = tbl_end[tbl_count];
        if (tbl_count >= ENTRIES || stg_len > STORE_BYTES - e) begin
          res.full = 1;
        end else begin
          for (int k = 0; k < stg_len; k++) tbl_bytes[e + k] = stg_bytes[k];
          res.added = 1;
          res.id = tbl_count[7:0];
          res.start = e[11:0];
          tbl_count++;
          tbl_end[tbl_count] = e + stg_len;
        end
      end
    end
    stg_len = 0;
    stg_ovf = 0;
    expected_results.push_back(res);
  endfunction

  // queue one string; the final byte carries the operation that counts
  task automatic queue_string(logic [1:0] op, logic [7:0] s[$]);
    req_t r;
    for (int k = 0; k < s.size(); k++) begin
      r.data = s[k];
      r.last = (k == s.size() - 1);
      // earlier bytes carry a random non-clear selector
      r.op = r.last ? op : ($urandom_range(0, 2) == 2 ? OP_INTERN : 2'($urandom_range(0, 1)));
      if (!r.last && $urandom_range(0, 9) == 0) r.op = OP_SPARE;
      pending_reqs.push_back(r);
    end
  endtask

  task automatic queue_clear();
    req_t r;
    r.op = OP_CLEAR;
    r.data = 8'($urandom);
    r.last = 1'($urandom);
    pending_reqs.push_back(r);
  endtask

  function automatic void rand_string(int unsigned len, output logic [7:0] s[$]);
    s = {};
    for (int k = 0; k < len; k++) s.push_back(8'($urandom));
  endfunction

  // driver; an idle burst only starts after an accepted request
  int idle_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      idle_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_table_step({in_operation, in_data_byte, in_last});
        n_sent <= n_sent + 1;
      end
      if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        in_valid <= 1'b0;
      end else if (!quiet && in_valid && $urandom_range(0, 5) == 0) begin
        idle_left <= $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_t r;
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_operation <= r.op;
        in_data_byte <= r.data;
        in_last <= r.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls in short bursts
  int stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(1, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      intern_res_t exp_r;
      n_results <= n_results + 1;
      if (expected_results.size() == 0) begin
        $error("unexpected result");
        n_errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_found !== exp_r.found) begin
          $error("found: exp %0d got %0d", exp_r.found, out_found);
          n_errors++;
        end
        if (out_added !== exp_r.added) begin
          $error("added: exp %0d got %0d", exp_r.added, out_added);
          n_errors++;
        end
        if (out_full_res !== exp_r.full) begin
          $error("full_res: exp %0d got %0d", exp_r.full, out_full_res);
          n_errors++;
        end
        if (out_entry_id !== exp_r.id) begin
          $error("entry_id: exp %0d got %0d", exp_r.id, out_entry_id);
          n_errors++;
        end
        if (out_start_offset !== exp_r.start) begin
          $error("start_offset: exp %0d got %0d", exp_r.start, out_start_offset);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("byte_string_intern_table_core regression: fail");
    $finish;
  end

  initial begin
    logic [7:0] s[$];
    int unsigned pick;
    int unsigned len;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_INTERN;
    in_data_byte = 8'd0;
    in_last = 1'b0;
    out_ready = 1'b1;
    n_errors = 0;
    n_results = 0;
    n_sent = 0;
    quiet = 0;
    tbl_count = 0;
    tbl_end[0] = 0;
    stg_len = 0;
    stg_ovf = 0;
    for (int p = 0; p < 16; p++) rand_string($urandom_range(1, 6), pool[p]);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte extremes, hit, check, overflow, clear, op three
    s = {8'h00}; queue_string(OP_INTERN, s);
    s = {8'hff}; queue_string(OP_INTERN, s);
    s = {8'h00}; queue_string(OP_INTERN, s);
    s = {8'hff}; queue_string(OP_CHECK, s);
    s = {8'h55, 8'haa}; queue_string(OP_CHECK, s);
    s = {8'h55, 8'haa}; queue_string(OP_SPARE, s);
    s = {8'h00, 8'h00}; queue_string(OP_INTERN, s);
    rand_string(MAX_STRING, s); queue_string(OP_INTERN, s);
    queue_string(OP_INTERN, s);
    rand_string(MAX_STRING + 1, s); queue_string(OP_INTERN, s);
    rand_string(MAX_STRING + 3, s); queue_string(OP_CHECK, s);
    queue_clear();
    s = {8'hff}; queue_string(OP_CHECK, s);
    s = {8'h12, 8'h34, 8'h56}; queue_string(OP_INTERN, s);
    s.delete(2); queue_string(OP_INTERN, s);
    queue_clear();

    // fill the entry limit with one-byte strings
    for (int k = 0; k < ENTRIES + 2; k++) begin
      s = {8'(k)};
      if (k >= ENTRIES) s = {8'(k), 8'h1};
      queue_string(OP_INTERN, s);
    end
    s = {8'h7}; queue_string(OP_INTERN, s);
    queue_clear();

    // random strings with pool reuse
    while (pending_reqs.size() < 1150) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        queue_clear();
      end else if (pick < 60) begin
        queue_string($urandom_range(0, 3) == 0 ? OP_CHECK : OP_INTERN,
                     pool[$urandom_range(0, 15)]);
      end else if (pick < 66) begin
        rand_string($urandom_range(MAX_STRING - 1, MAX_STRING + 2), s);
        queue_string(2'($urandom_range(0, 1)), s);
      end else begin
        len = $urandom_range(1, 12);
        rand_string(len, s);
        queue_string(($urandom_range(0, 7) == 0) ? OP_SPARE : 2'($urandom_range(0, 1)), s);
      end
    end

    while (pending_reqs.size() >= 60) @(posedge clk);
    quiet = 1;
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d byte requests, %0d results: hits, inserts, overflow,", n_sent,
             n_results);
    $display("check-only, clear and entry exhaustion");
    if (n_errors == 0 && expected_results.size() == 0)
      $display("byte_string_intern_table_core regression: pass");
    else
      $display("byte_string_intern_table_core regression: fail");
    $finish;
  end
endmodule

### filelist.f
src/bsit_pkg.sv
src/bsit_datapath.sv
src/bsit_ctrl.sv
src/byte_string_intern_table_core.sv
src/bsit_checker.sv
verif/tb_byte_string_intern_table_core.sv
